// File: hdl/lswc_pkg.sv
package lswc_pkg;

   localparam int CoordW = 16;
   localparam int DiffW  = 17;
   localparam int NumBounds = 4;

   typedef enum logic [1:0] {
      REG_LEFT   = 2'd0,
      REG_RIGHT  = 2'd1,
      REG_BOTTOM = 2'd2,
      REG_TOP    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic [DiffW-1:0] dx;
      logic [DiffW-1:0] dy;
      logic [DiffW-1:0] q_left;
      logic [DiffW-1:0] q_right;
      logic [DiffW-1:0] q_bottom;
      logic [DiffW-1:0] q_top;
   } seg_type;

endpackage

// File: hdl/lswc_div.sv
// Restoring divider row: one cell per quotient bit, each cell one subtract/compare.
module lswc_div #(
   parameter int NumW = 40,
   parameter int DenW = 17,
   parameter int TagW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [NumW-1:0] in_num,
   input  logic [DenW-1:0] in_den,
   input  logic [TagW-1:0] in_tag,
   output logic            out_valid,
   output logic [NumW-1:0] out_quo,
   output logic [TagW-1:0] out_tag
);
   localparam int RemW = DenW + 1;

   logic            v_ff   [NumW+1];
   logic [NumW-1:0] n_ff   [NumW+1];
   logic [RemW-1:0] r_ff   [NumW+1];
   logic [DenW-1:0] d_ff   [NumW+1];
   logic [TagW-1:0] t_ff   [NumW+1];

   always_comb begin
      v_ff[0] = in_valid;
      n_ff[0] = in_num;
      r_ff[0] = '0;
      d_ff[0] = in_den;
      t_ff[0] = in_tag;
   end

   for (genvar k = 0; k < NumW; k++) begin : g_cell
      logic [RemW-1:0] shifted_in;
      logic [RemW:0]   diff_in;
      logic            v_hold_ff;
      logic [NumW-1:0] n_hold_ff;
      logic [RemW-1:0] r_hold_ff;
      logic [DenW-1:0] d_hold_ff;
      logic [TagW-1:0] t_hold_ff;
      always_comb begin
         shifted_in = {r_ff[k][RemW-2:0], n_ff[k][NumW-1]};
         diff_in    = {1'b0, shifted_in} - {2'b00, d_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_hold_ff <= 1'b0;
         end else begin
            v_hold_ff <= v_ff[k];
         end
         d_hold_ff <= d_ff[k];
         t_hold_ff <= t_ff[k];
         if (!diff_in[RemW]) begin
            r_hold_ff <= diff_in[RemW-1:0];
            n_hold_ff <= {n_ff[k][NumW-2:0], 1'b1};
         end else begin
            r_hold_ff <= shifted_in;
            n_hold_ff <= {n_ff[k][NumW-2:0], 1'b0};
         end
      end
      always_comb begin
         v_ff[k+1] = v_hold_ff;
         n_ff[k+1] = n_hold_ff;
         r_ff[k+1] = r_hold_ff;
         d_ff[k+1] = d_hold_ff;
         t_ff[k+1] = t_hold_ff;
      end
   end

   assign out_valid = v_ff[NumW];
   assign out_quo   = n_ff[NumW];
   assign out_tag   = t_ff[NumW];
endmodule

// File: hdl/lswc_cell.sv
// One boundary cell: ratio via divider row, then narrow entry/exit.
module lswc_cell #(
   parameter int FracW = 16,
   parameter int TW    = 33
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic                          in_ok,
   input  logic signed [TW-1:0]          in_tin,
   input  logic signed [TW-1:0]          in_tout,
   input  lswc_pkg::seg_type             in_seg,
   input  logic signed [lswc_pkg::DiffW-1:0] p,
   input  logic signed [lswc_pkg::DiffW-1:0] q,
   output logic                          out_valid,
   output logic                          out_ok,
   output logic signed [TW-1:0]          out_tin,
   output logic signed [TW-1:0]          out_tout,
   output lswc_pkg::seg_type             out_seg
);
   localparam int DW   = lswc_pkg::DiffW;
   localparam int NumW = DW + FracW;
   localparam int SW   = (NumW + 1 > TW) ? NumW + 1 : TW;
   localparam int TagW = 1 + 2 * TW + $bits(lswc_pkg::seg_type) + 3;
   localparam logic signed [TW-1:0] SMax = TW'(64'sh7FFF_FFFF);
   localparam logic signed [TW-1:0] SMin = -SMax - TW'(1);

   logic            neg_q, neg_p, p_zero;
   logic [DW-1:0]   mag_q, mag_p;
   logic [NumW-1:0] num;
   logic [TagW-1:0] tag_in, tag_out;
   logic            dv;
   logic [NumW-1:0] quo;

   always_comb begin
      neg_q  = q[DW-1];
      neg_p  = p[DW-1];
      p_zero = (p == '0);
      mag_q  = neg_q ? DW'(-q) : DW'(q);
      mag_p  = neg_p ? DW'(-p) : DW'(p);
      num    = {mag_q, {FracW{1'b0}}};
      tag_in = {in_ok, in_tin, in_tout, in_seg, neg_q ^ neg_p, p_zero, neg_p};
   end

   lswc_div #(.NumW(NumW), .DenW(DW), .TagW(TagW)) u_div (
      .clock(clock), .reset(reset),
      .in_valid(in_valid), .in_num(num),
      .in_den(p_zero ? DW'(1) : mag_p), .in_tag(tag_in),
      .out_valid(dv), .out_quo(quo), .out_tag(tag_out)
   );

   logic                 t_ok, t_sneg, t_pz, t_pneg;
   logic signed [TW-1:0] t_tin, t_tout;
   lswc_pkg::seg_type    t_seg;
   logic signed [SW-1:0] sq;
   logic signed [TW-1:0] r;
   logic                 ok_in;
   logic signed [TW-1:0] tin_in, tout_in;
   logic                 v_ff, ok_ff;
   logic signed [TW-1:0] tin_ff, tout_ff;
   lswc_pkg::seg_type    seg_ff;

   always_comb begin
      {t_ok, t_tin, t_tout, t_seg, t_sneg, t_pz, t_pneg} = tag_out;
      sq = t_sneg ? -SW'($signed({1'b0, quo})) : SW'($signed({1'b0, quo}));
      if (sq > SW'(SMax))      r = SMax;
      else if (sq < SW'(SMin)) r = SMin;
      else                     r = TW'(sq);
      ok_in   = t_ok;
      tin_in  = t_tin;
      tout_in = t_tout;
      if (t_pz) begin
         if (t_sneg ^ t_pneg) ok_in = 1'b0;
      end else if (t_pneg) begin
         if (r > t_tout)     ok_in  = 1'b0;
         else if (r > t_tin) tin_in = r;
      end else begin
         if (r < t_tin)       ok_in   = 1'b0;
         else if (r < t_tout) tout_in = r;
      end
      if (!t_ok) begin
         tin_in  = t_tin;
         tout_in = t_tout;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= dv;
      end
      ok_ff   <= ok_in;
      tin_ff  <= tin_in;
      tout_ff <= tout_in;
      seg_ff  <= t_seg;
   end

   assign out_valid = v_ff;
   assign out_ok    = ok_ff;
   assign out_tin   = tin_ff;
   assign out_tout  = tout_ff;
   assign out_seg   = seg_ff;
endmodule

// File: hdl/line_segment_window_clipper.sv
// channel | ports                                   | direction
// req     | req_valid/req_ready + start/end x,y     | in
// rsp     | rsp_valid/rsp_ready + visible,t_enter,t_exit | out
// csr     | APB psel/penable/pwrite/paddr/pwdata    | in, prdata out
// One segment per cycle while req_ready is high; every divider row of the
// boundary chain is fully pipelined.
// Synchronous active-high reset empties the pipeline and zeroes the window.
// The pipeline never stalls; req_ready drops while in-flight plus queued
// segments fill the result queue, so a stalled rsp backs up to req.
module line_segment_window_clipper #(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_start_x,
   input  logic [15:0] req_start_y,
   input  logic [15:0] req_end_x,
   input  logic [15:0] req_end_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_visible,
   output logic [FRACTION_BITS:0] rsp_t_enter,
   output logic [FRACTION_BITS:0] rsp_t_exit,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int DW    = lswc_pkg::DiffW;
   localparam int TW    = 33;
   localparam int Lat   = lswc_pkg::NumBounds * (DW + FRACTION_BITS + 1) + 1;
   localparam int QD    = Lat + 2;
   localparam int QAW   = $clog2(QD);
   localparam int OW    = 1 + 2 * (FRACTION_BITS + 1);

   logic signed [15:0] left_ff, right_ff, bottom_ff, top_ff;
   logic [1:0] ridx;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0; right_ff <= '0; bottom_ff <= '0; top_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (lswc_pkg::reg_index_type'(ridx))
            lswc_pkg::REG_LEFT:   left_ff   <= csr_pwdata[15:0];
            lswc_pkg::REG_RIGHT:  right_ff  <= csr_pwdata[15:0];
            lswc_pkg::REG_BOTTOM: bottom_ff <= csr_pwdata[15:0];
            lswc_pkg::REG_TOP:    top_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (lswc_pkg::reg_index_type'(ridx))
         lswc_pkg::REG_LEFT:   csr_prdata = {{16{left_ff[15]}}, left_ff};
         lswc_pkg::REG_RIGHT:  csr_prdata = {{16{right_ff[15]}}, right_ff};
         lswc_pkg::REG_BOTTOM: csr_prdata = {{16{bottom_ff[15]}}, bottom_ff};
         lswc_pkg::REG_TOP:    csr_prdata = {{16{top_ff[15]}}, top_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // credit: in-flight plus queued never exceeds queue depth
   logic [QAW:0] credit_ff, credit_in;
   logic         acc_in, pop;
   assign req_ready = (credit_ff != '0);
   assign acc_in    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   always_comb begin
      credit_in = credit_ff;
      if (acc_in && !pop) credit_in = credit_ff - (QAW+1)'(1);
      else if (!acc_in && pop) credit_in = credit_ff + (QAW+1)'(1);
   end
   always_ff @(posedge clock) begin
      if (reset) credit_ff <= (QAW+1)'(QD);
      else       credit_ff <= credit_in;
   end

   // front: differences
   lswc_pkg::seg_type s0_ff, s0_in;
   always_comb begin
      s0_in.valid    = acc_in;
      s0_in.ok       = 1'b1;
      s0_in.dx       = DW'($signed(req_end_x)) - DW'($signed(req_start_x));
      s0_in.dy       = DW'($signed(req_end_y)) - DW'($signed(req_start_y));
      s0_in.q_left   = DW'($signed(req_start_x)) - DW'(left_ff);
      s0_in.q_right  = DW'(right_ff) - DW'($signed(req_start_x));
      s0_in.q_bottom = DW'($signed(req_start_y)) - DW'(bottom_ff);
      s0_in.q_top    = DW'(top_ff) - DW'($signed(req_start_y));
   end
   always_ff @(posedge clock) begin
      if (reset) s0_ff.valid <= 1'b0;
      else       s0_ff.valid <= s0_in.valid;
      s0_ff.ok       <= s0_in.ok;
      s0_ff.dx       <= s0_in.dx;
      s0_ff.dy       <= s0_in.dy;
      s0_ff.q_left   <= s0_in.q_left;
      s0_ff.q_right  <= s0_in.q_right;
      s0_ff.q_bottom <= s0_in.q_bottom;
      s0_ff.q_top    <= s0_in.q_top;
   end

   logic                 cv   [5];
   logic                 cok  [5];
   logic signed [TW-1:0] ctin [5];
   logic signed [TW-1:0] ctout[5];
   lswc_pkg::seg_type    cseg [5];
   logic signed [DW-1:0] cp   [4];
   logic signed [DW-1:0] cq   [4];

   always_comb begin
      cv[0]    = s0_ff.valid;
      cok[0]   = 1'b1;
      ctin[0]  = '0;
      ctout[0] = TW'(64'd1 << FRACTION_BITS);
      cseg[0]  = s0_ff;
      cp[0] = -$signed(cseg[0].dx); cq[0] = $signed(cseg[0].q_left);
      cp[1] =  $signed(cseg[1].dx); cq[1] = $signed(cseg[1].q_right);
      cp[2] = -$signed(cseg[2].dy); cq[2] = $signed(cseg[2].q_bottom);
      cp[3] =  $signed(cseg[3].dy); cq[3] = $signed(cseg[3].q_top);
   end

   for (genvar b = 0; b < lswc_pkg::NumBounds; b++) begin : g_bound
      lswc_cell #(.FracW(FRACTION_BITS), .TW(TW)) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(cv[b]), .in_ok(cok[b]), .in_tin(ctin[b]), .in_tout(ctout[b]),
         .in_seg(cseg[b]), .p(cp[b]), .q(cq[b]),
         .out_valid(cv[b+1]), .out_ok(cok[b+1]), .out_tin(ctin[b+1]),
         .out_tout(ctout[b+1]), .out_seg(cseg[b+1])
      );
   end

   logic          vis;
   logic [OW-1:0] res;
   always_comb begin
      vis = cok[4] && (ctin[4] < ctout[4]);
      res = vis ? {1'b1, ctin[4][FRACTION_BITS:0], ctout[4][FRACTION_BITS:0]} : '0;
   end

   // result queue; head entry held in a registered read
   logic [OW-1:0] q_mem [QD];
   logic [QAW-1:0] wp_ff, rp_ff, rp_in;
   logic [QAW:0]   cnt_ff;
   logic [OW-1:0]  rdata_ff;
   always_comb begin
      rp_in = rp_ff;
      if (pop) rp_in = (rp_ff == QAW'(QD-1)) ? '0 : rp_ff + QAW'(1);
   end
   always_ff @(posedge clock) begin
      if (cv[4]) q_mem[wp_ff] <= res;
      if (cv[4] && (wp_ff == rp_in)) rdata_ff <= res;
      else                           rdata_ff <= q_mem[rp_in];
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (cv[4]) wp_ff <= (wp_ff == QAW'(QD-1)) ? '0 : wp_ff + QAW'(1);
         rp_ff  <= rp_in;
         cnt_ff <= cnt_ff + (QAW+1)'(cv[4]) - (QAW+1)'(pop);
      end
   end
   assign rsp_valid = (cnt_ff != '0);
   assign {rsp_visible, rsp_t_enter, rsp_t_exit} = rdata_ff;

   a_credit: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= (QAW+1)'(QD)) else $error("credit overflow");
   a_noover: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QAW+1)'(QD)) else $error("queue overflow");
   a_novis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_t_enter == '0 && rsp_t_exit == '0)
      else $error("rejected result with nonzero params");
endmodule
